### rtl/core/ukvt_pkg.sv
// Shared constants, command codes, operation classes and width helpers of the key/value table.
package ukvt_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CMD_W           = 3;
    localparam int POS_W           = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_UPDATE = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_UPSERT = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_ERASE  = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_LOOKUP = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(5);

    typedef enum logic [2:0] {
        CLS_INSERT,
        CLS_UPDATE,
        CLS_UPSERT,
        CLS_ERASE,
        CLS_LOOKUP,
        CLS_READ,
        CLS_REJECT
    } op_cls_t;

    localparam int CLS_W = $bits(op_cls_t);

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int cnt_width(input int n);
        return $clog2(n + 1);
    endfunction

    function automatic int item_width(input int kw, input int vw);
        return CLS_W + kw + vw + POS_W;
    endfunction

endpackage

### rtl/core/ukvt_cmd_if.sv
// Command channel of the key/value table: valid, ready and the command payload.
interface ukvt_cmd_if #(
    parameter int KEY_WIDTH   = ukvt_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = ukvt_pkg::VALUE_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic [ukvt_pkg::CMD_W-1:0]  command;
    logic [KEY_WIDTH-1:0]        key_in;
    logic [VALUE_WIDTH-1:0]      value_in;
    logic [ukvt_pkg::POS_W-1:0]  position;

    modport source (output valid, command, key_in, value_in, position, input ready);
    modport sink   (input valid, command, key_in, value_in, position, output ready);
endinterface

### rtl/core/ukvt_rsp_if.sv
// Response channel of the key/value table: valid, ready and the result payload.
interface ukvt_rsp_if #(
    parameter int KEY_WIDTH   = ukvt_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = ukvt_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = ukvt_pkg::cnt_width(ukvt_pkg::CAPACITY_DEF)
);
    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [KEY_WIDTH-1:0]   key_out;
    logic [VALUE_WIDTH-1:0] value_out;
    logic [COUNT_WIDTH-1:0] entry_count;

    modport source (output valid, ok, key_out, value_out, entry_count, input ready);
    modport sink   (input valid, ok, key_out, value_out, entry_count, output ready);
endinterface

### rtl/core/unsorted_key_value_table.sv
// Top level of the unsorted key/value table: front end, command queue and back end.
//
// The table holds up to CAPACITY unique key/value pairs in no order, with a live entry count,
// and gives one response per command. Every command that names a key runs a linear scan that
// reads one entry a cycle from the key and value RAMs. An erase that finds its key then moves
// the last entry into the freed slot. A read by index that hits a live entry reads the RAMs
// first, and a failed read or an unused command code is answered straight from idle. A
// two-entry queue takes commands while a scan runs. A response register holds a result until
// its transfer, and the back end starts no new command during that time. The next command is
// taken in the cycle after the transfer. The RAM contents are not cleared at reset: only
// entries below the count are ever read.
module unsorted_key_value_table #(
    parameter int CAPACITY    = ukvt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH   = ukvt_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = ukvt_pkg::VALUE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ukvt_cmd_if.sink   cmd,
    ukvt_rsp_if.source rsp
);

    localparam int ITEM_W  = ukvt_pkg::item_width(KEY_WIDTH, VALUE_WIDTH);
    localparam int COUNT_W = ukvt_pkg::cnt_width(CAPACITY);

    logic              push_valid;
    logic              push_ready;
    logic [ITEM_W-1:0] push_data;
    logic              pop_valid;
    logic              pop_ready;
    logic [ITEM_W-1:0] pop_data;

    ukvt_front #(
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ukvt_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (ukvt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ukvt_back #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item_data  (pop_data),
        .rsp        (rsp)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.entry_count <= COUNT_W'(CAPACITY)))
        else $error("Reported entry count exceeds the capacity.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.key_out == '0 && rsp.value_out == '0))
        else $error("A failed response carries a non-zero key or value.");

    a_stall_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> pop_valid)
        else $error("Command channel stalled while the queue is empty.");

    a_read_key_only: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.key_out != '0) |-> rsp.ok)
        else $error("A key was returned by a response that did not succeed.");

endmodule

### rtl/core/ukvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ukvt_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 256,
    localparam int ADDR_W = ukvt_pkg::idx_width(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/ukvt_queue.sv
// Short first-in first-out queue between the command front end and the execution back end.
module ukvt_queue #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = ukvt_pkg::QUEUE_DEPTH,
    localparam int PTR_W = ukvt_pkg::idx_width(DEPTH),
    localparam int LVL_W = ukvt_pkg::cnt_width(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             push;
    logic             pop;

    assign push_ready = (level_reg != LVL_W'(DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/ukvt_front.sv
// Front end: accepts commands, classifies them and pushes them into the queue.
module ukvt_front #(
    parameter int  KEY_WIDTH   = ukvt_pkg::KEY_WIDTH_DEF,
    parameter int  VALUE_WIDTH = ukvt_pkg::VALUE_WIDTH_DEF,
    localparam int ITEM_W      = ukvt_pkg::item_width(KEY_WIDTH, VALUE_WIDTH)
) (
    ukvt_cmd_if.sink          cmd,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [ITEM_W-1:0] push_data
);

    ukvt_pkg::op_cls_t cls;

    always_comb
    begin
        case (cmd.command)
            ukvt_pkg::CMD_INSERT: cls = ukvt_pkg::CLS_INSERT;
            ukvt_pkg::CMD_UPDATE: cls = ukvt_pkg::CLS_UPDATE;
            ukvt_pkg::CMD_UPSERT: cls = ukvt_pkg::CLS_UPSERT;
            ukvt_pkg::CMD_ERASE:  cls = ukvt_pkg::CLS_ERASE;
            ukvt_pkg::CMD_LOOKUP: cls = ukvt_pkg::CLS_LOOKUP;
            ukvt_pkg::CMD_READ:   cls = ukvt_pkg::CLS_READ;
            default:              cls = ukvt_pkg::CLS_REJECT;
        endcase
    end

    assign push_valid = cmd.valid;
    assign cmd.ready  = push_ready;
    assign push_data  = {cls, cmd.key_in, cmd.value_in, cmd.position};

endmodule

### rtl/core/ukvt_back.sv
// Back end: scans the stores for a key, carries out each command and registers its result.
module ukvt_back #(
    parameter int  CAPACITY    = ukvt_pkg::CAPACITY_DEF,
    parameter int  KEY_WIDTH   = ukvt_pkg::KEY_WIDTH_DEF,
    parameter int  VALUE_WIDTH = ukvt_pkg::VALUE_WIDTH_DEF,
    localparam int ADDR_W      = ukvt_pkg::idx_width(CAPACITY),
    localparam int COUNT_W     = ukvt_pkg::cnt_width(CAPACITY),
    localparam int ITEM_W      = ukvt_pkg::item_width(KEY_WIDTH, VALUE_WIDTH),
    localparam int POS_W       = ukvt_pkg::POS_W,
    localparam int WIDE_W      = POS_W + COUNT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [ITEM_W-1:0] item_data,
    ukvt_rsp_if.source        rsp
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_ACT  = 5'b00100,
        S_MOVE = 5'b01000,
        S_READ = 5'b10000
    } back_state_t;

    back_state_t             state_reg;
    back_state_t             state_next;
    ukvt_pkg::op_cls_t       cls_reg;
    ukvt_pkg::op_cls_t       cls_next;
    logic [KEY_WIDTH-1:0]    key_reg;
    logic [KEY_WIDTH-1:0]    key_next;
    logic [VALUE_WIDTH-1:0]  val_reg;
    logic [VALUE_WIDTH-1:0]  val_next;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic [COUNT_W-1:0]      issue_reg;
    logic [COUNT_W-1:0]      issue_next;
    logic                    cmp_valid_reg;
    logic                    cmp_valid_next;
    logic [ADDR_W-1:0]       cmp_idx_reg;
    logic [ADDR_W-1:0]       cmp_idx_next;
    logic [ADDR_W-1:0]       slot_reg;
    logic [ADDR_W-1:0]       slot_next;
    logic                    found_reg;
    logic                    found_next;
    logic [VALUE_WIDTH-1:0]  fval_reg;
    logic [VALUE_WIDTH-1:0]  fval_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_ok_reg;
    logic                    out_ok_next;
    logic [KEY_WIDTH-1:0]    out_key_reg;
    logic [KEY_WIDTH-1:0]    out_key_next;
    logic [VALUE_WIDTH-1:0]  out_val_reg;
    logic [VALUE_WIDTH-1:0]  out_val_next;
    logic [COUNT_W-1:0]      out_cnt_reg;
    logic [COUNT_W-1:0]      out_cnt_next;

    ukvt_pkg::op_cls_t       head_cls;
    logic [KEY_WIDTH-1:0]    head_key;
    logic [VALUE_WIDTH-1:0]  head_val;
    logic [POS_W-1:0]        head_pos;
    logic [WIDE_W-1:0]       pos_wide;
    logic [WIDE_W-1:0]       cnt_wide;
    logic [COUNT_W-1:0]      last_cnt;
    logic                    pop;
    logic                    match;

    logic                    key_wr_en;
    logic                    val_wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [KEY_WIDTH-1:0]    key_wdata;
    logic [VALUE_WIDTH-1:0]  val_wdata;
    logic [ADDR_W-1:0]       rd_addr;
    logic [KEY_WIDTH-1:0]    key_rdata;
    logic [VALUE_WIDTH-1:0]  val_rdata;

    logic                    produce;
    logic                    res_ok;
    logic [KEY_WIDTH-1:0]    res_key;
    logic [VALUE_WIDTH-1:0]  res_val;

    assign head_cls = ukvt_pkg::op_cls_t'(item_data[ITEM_W-1 -: ukvt_pkg::CLS_W]);
    assign head_key = item_data[POS_W + VALUE_WIDTH +: KEY_WIDTH];
    assign head_val = item_data[POS_W +: VALUE_WIDTH];
    assign head_pos = item_data[POS_W-1:0];
    assign pos_wide = {{COUNT_W{1'b0}}, head_pos};
    assign cnt_wide = {{POS_W{1'b0}}, count_reg};
    assign last_cnt = count_reg - COUNT_W'(1);

    assign item_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign pop        = item_valid && item_ready;
    assign match      = cmp_valid_reg && (key_rdata == key_reg);

    ukvt_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_wdata),
        .rd_addr (rd_addr),
        .rd_data (key_rdata)
    );

    ukvt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (wr_addr),
        .wr_data (val_wdata),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        fval_next      = fval_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_key_next   = out_key_reg;
        out_val_next   = out_val_reg;
        out_cnt_next   = out_cnt_reg;
        key_wr_en      = 1'b0;
        val_wr_en      = 1'b0;
        wr_addr        = slot_reg;
        key_wdata      = key_reg;
        val_wdata      = val_reg;
        rd_addr        = issue_reg[ADDR_W-1:0];
        produce        = 1'b0;
        res_ok         = 1'b0;
        res_key        = '0;
        res_val        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    cls_next   = head_cls;
                    key_next   = head_key;
                    val_next   = head_val;
                    issue_next = '0;
                    found_next = 1'b0;
                    case (head_cls)
                        ukvt_pkg::CLS_READ:
                        begin
                            if (pos_wide < cnt_wide)
                            begin
                                rd_addr    = pos_wide[ADDR_W-1:0];
                                state_next = S_READ;
                            end
                            else
                            begin
                                produce = 1'b1;
                            end
                        end
                        ukvt_pkg::CLS_REJECT:
                        begin
                            produce = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    slot_next  = cmp_idx_reg;
                    fval_next  = val_rdata;
                    state_next = S_ACT;
                end
                else if (issue_reg < count_reg)
                begin
                    rd_addr        = issue_reg[ADDR_W-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[ADDR_W-1:0];
                    issue_next     = issue_reg + 1'b1;
                end
                else
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = S_IDLE;
                case (cls_reg)
                    ukvt_pkg::CLS_INSERT, ukvt_pkg::CLS_UPSERT:
                    begin
                        produce = 1'b1;
                        if (found_reg)
                        begin
                            if (cls_reg == ukvt_pkg::CLS_UPSERT)
                            begin
                                val_wr_en = 1'b1;
                                res_ok    = 1'b1;
                            end
                        end
                        else if (count_reg < COUNT_W'(CAPACITY))
                        begin
                            wr_addr    = count_reg[ADDR_W-1:0];
                            key_wr_en  = 1'b1;
                            val_wr_en  = 1'b1;
                            count_next = count_reg + 1'b1;
                            res_ok     = 1'b1;
                        end
                    end
                    ukvt_pkg::CLS_UPDATE:
                    begin
                        produce   = 1'b1;
                        val_wr_en = found_reg;
                        res_ok    = found_reg;
                    end
                    ukvt_pkg::CLS_ERASE:
                    begin
                        if (found_reg)
                        begin
                            rd_addr    = last_cnt[ADDR_W-1:0];
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            produce = 1'b1;
                        end
                    end
                    ukvt_pkg::CLS_LOOKUP:
                    begin
                        produce = 1'b1;
                        res_ok  = found_reg;
                        res_val = found_reg ? fval_reg : '0;
                    end
                    default:
                    begin
                        produce = 1'b1;
                    end
                endcase
            end
            S_MOVE:
            begin
                key_wdata  = key_rdata;
                val_wdata  = val_rdata;
                key_wr_en  = 1'b1;
                val_wr_en  = 1'b1;
                count_next = last_cnt;
                produce    = 1'b1;
                res_ok     = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                produce    = 1'b1;
                res_ok     = 1'b1;
                res_key    = key_rdata;
                res_val    = val_rdata;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (produce)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = res_ok;
            out_key_next   = res_key;
            out_val_next   = res_val;
            out_cnt_next   = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg     <= cls_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        fval_reg    <= fval_next;
        out_ok_reg  <= out_ok_next;
        out_key_reg <= out_key_next;
        out_val_reg <= out_val_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.key_out     = out_key_reg;
    assign rsp.value_out   = out_val_reg;
    assign rsp.entry_count = out_cnt_reg;

endmodule

### tb/sv/unsorted_key_value_table_tb.sv
// Self-checking testbench of the unsorted key/value table with a built-in table predictor.
`timescale 1ns / 1ps

module unsorted_key_value_table_tb;

    localparam int CAPACITY     = ukvt_pkg::CAPACITY_DEF;
    localparam int KEY_W        = ukvt_pkg::KEY_WIDTH_DEF;
    localparam int VAL_W        = ukvt_pkg::VALUE_WIDTH_DEF;
    localparam int CMD_W        = ukvt_pkg::CMD_W;
    localparam int POS_W        = ukvt_pkg::POS_W;
    localparam int COUNT_W      = $clog2(CAPACITY + 1);
    localparam int HOLD_CYCLES  = 900;
    localparam int HOLD_FIRST   = 250;
    localparam int HOLD_SPACING = 700;
    localparam int DRAIN_CYCLES = CAPACITY + 16;
    localparam longint TIMEOUT_NS = 64'd6_000_000;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(6);
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = CMD_W'(7);

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
    } kv_cmd_t;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [COUNT_W-1:0] count;
    } kv_rsp_t;

    logic clk;
    logic rst_n;

    ukvt_cmd_if #(.KEY_WIDTH(KEY_W), .VALUE_WIDTH(VAL_W)) cmd_ch ();
    ukvt_rsp_if #(.KEY_WIDTH(KEY_W), .VALUE_WIDTH(VAL_W), .COUNT_WIDTH(COUNT_W)) rsp_ch ();

    unsorted_key_value_table #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_W),
        .VALUE_WIDTH (VAL_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    logic [KEY_W-1:0] stored_keys [CAPACITY];
    logic [VAL_W-1:0] stored_values [CAPACITY];
    int               live_entries = 0;

    kv_cmd_t          queued_commands [$];
    kv_rsp_t          predicted_responses [$];
    logic [KEY_W-1:0] key_pool [$];

    int mismatches = 0;
    int cmds_accepted;
    int burst_left;
    int gap_left;
    int hold_left;
    int hold_mark;
    int stall_mode;
    int mode_left;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic kv_rsp_t table_apply(input kv_cmd_t c);
        int      slot;
        int      last;
        kv_rsp_t r;
        slot = -1;
        r = '0;
        for (int i = 0; i < live_entries; i++)
        begin
            if (slot < 0 && stored_keys[i] == c.key)
                slot = i;
        end
        case (c.command)
            ukvt_pkg::CMD_INSERT, ukvt_pkg::CMD_UPSERT:
            begin
                if (slot >= 0)
                begin
                    if (c.command == ukvt_pkg::CMD_UPSERT)
                    begin
                        stored_values[slot] = c.value;
                        r.ok = 1'b1;
                    end
                end
                else if (live_entries < CAPACITY)
                begin
                    stored_keys[live_entries] = c.key;
                    stored_values[live_entries] = c.value;
                    live_entries++;
                    r.ok = 1'b1;
                end
            end
            ukvt_pkg::CMD_UPDATE:
            begin
                if (slot >= 0)
                begin
                    stored_values[slot] = c.value;
                    r.ok = 1'b1;
                end
            end
            ukvt_pkg::CMD_ERASE:
            begin
                if (slot >= 0)
                begin
                    last = live_entries - 1;
                    stored_keys[slot] = stored_keys[last];
                    stored_values[slot] = stored_values[last];
                    live_entries = last;
                    r.ok = 1'b1;
                end
            end
            ukvt_pkg::CMD_LOOKUP:
            begin
                if (slot >= 0)
                begin
                    r.value = stored_values[slot];
                    r.ok = 1'b1;
                end
            end
            ukvt_pkg::CMD_READ:
            begin
                if (int'(c.position) < live_entries)
                begin
                    r.key = stored_keys[c.position];
                    r.value = stored_values[c.position];
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(live_entries);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        kv_cmd_t got;
        kv_cmd_t nxt;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.command <= ukvt_pkg::CMD_INSERT;
            cmd_ch.key_in <= '0;
            cmd_ch.value_in <= '0;
            cmd_ch.position <= '0;
            cmds_accepted <= 0;
            burst_left <= 1;
            gap_left <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                got.command = cmd_ch.command;
                got.key = cmd_ch.key_in;
                got.value = cmd_ch.value_in;
                got.position = cmd_ch.position;
                predicted_responses.push_back(table_apply(got));
                cmds_accepted <= cmds_accepted + 1;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    cmd_ch.valid <= 1'b0;
                end
                else if (queued_commands.size() != 0)
                begin
                    nxt = queued_commands.pop_front();
                    cmd_ch.command <= nxt.command;
                    cmd_ch.key_in <= nxt.key;
                    cmd_ch.value_in <= nxt.value;
                    cmd_ch.position <= nxt.position;
                    cmd_ch.valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // A long hold-off is started whenever the count of accepted commands reaches the next mark.
    always @(posedge clk or negedge rst_n)
    begin : rsp_stall
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= 0;
            hold_mark <= HOLD_FIRST;
            stall_mode <= 0;
            mode_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (cmds_accepted >= hold_mark)
        begin
            hold_left <= HOLD_CYCLES;
            hold_mark <= hold_mark + HOLD_SPACING;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 120);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                default: rsp_ch.ready <= ~rsp_ch.ready;
            endcase
        end
    end

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : rsp_monitor
        kv_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (predicted_responses.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, %s %0d key %h value %h count %0d",
                         $time, "actual ok", rsp_ch.ok, rsp_ch.key_out, rsp_ch.value_out,
                         rsp_ch.entry_count);
                mismatches++;
            end
            else
            begin
                want = predicted_responses.pop_front();
                check_field("ok", 64'(want.ok), 64'(rsp_ch.ok));
                check_field("key_out", 64'(want.key), 64'(rsp_ch.key_out));
                check_field("value_out", 64'(want.value), 64'(rsp_ch.value_out));
                check_field("entry_count", 64'(want.count), 64'(rsp_ch.entry_count));
            end
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v, input logic [POS_W-1:0] p);
        kv_cmd_t c;
        c.command = op;
        c.key = k;
        c.value = v;
        c.position = p;
        queued_commands.push_back(c);
    endtask

    task automatic wait_drained();
        while (queued_commands.size() != 0 || cmd_ch.valid || predicted_responses.size() != 0)
            @(negedge clk);
    endtask

    task automatic make_pool(input int n);
        int pick;
        key_pool.delete();
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                key_pool.push_back('0);
            else if (pick == 1)
                key_pool.push_back('1);
            else if (pick == 2)
                key_pool.push_back(KEY_W'($urandom_range(1, 64)));
            else
                key_pool.push_back(KEY_W'($urandom));
        end
    endtask

    task automatic run_mix(input int n_items, input int w_ins, input int w_upd, input int w_ups,
                           input int w_era, input int w_look, input int w_read, input int w_spare);
        int               total;
        int               r;
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] k;
        logic [POS_W-1:0] p;
        total = w_ins + w_upd + w_ups + w_era + w_look + w_read + w_spare;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, total - 1);
            if (r < w_ins)
                op = ukvt_pkg::CMD_INSERT;
            else if (r < w_ins + w_upd)
                op = ukvt_pkg::CMD_UPDATE;
            else if (r < w_ins + w_upd + w_ups)
                op = ukvt_pkg::CMD_UPSERT;
            else if (r < w_ins + w_upd + w_ups + w_era)
                op = ukvt_pkg::CMD_ERASE;
            else if (r < w_ins + w_upd + w_ups + w_era + w_look)
                op = ukvt_pkg::CMD_LOOKUP;
            else if (r < total - w_spare)
                op = ukvt_pkg::CMD_READ;
            else
                op = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            if ($urandom_range(0, 7) == 0)
                k = KEY_W'($urandom);
            else
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if (op == ukvt_pkg::CMD_READ && $urandom_range(0, 3) != 0)
                p = POS_W'($urandom_range(0, (key_pool.size() > 255) ? 255 : key_pool.size()));
            else
                p = POS_W'($urandom_range(0, 255));
            queue_cmd(op, k, VAL_W'($urandom), p);
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Commands on the empty table, then extreme keys and values, duplicates and moves.
        queue_cmd(ukvt_pkg::CMD_LOOKUP, '0, '0, '0);
        queue_cmd(ukvt_pkg::CMD_ERASE, '1, '0, '0);
        queue_cmd(ukvt_pkg::CMD_UPDATE, '0, '1, '0);
        queue_cmd(ukvt_pkg::CMD_READ, '0, '0, '0);
        queue_cmd(ukvt_pkg::CMD_INSERT, '0, '1, '0);
        queue_cmd(ukvt_pkg::CMD_INSERT, '1, '0, '1);
        queue_cmd(ukvt_pkg::CMD_INSERT, '0, VAL_W'(1), '0);
        queue_cmd(ukvt_pkg::CMD_LOOKUP, '0, '0, '0);
        queue_cmd(ukvt_pkg::CMD_LOOKUP, '1, '1, '1);
        queue_cmd(ukvt_pkg::CMD_UPSERT, '0, VAL_W'(32'hA5A5_A5A5), '0);
        queue_cmd(ukvt_pkg::CMD_UPSERT, KEY_W'(32'h1234_5678), VAL_W'(32'h5A5A_5A5A), '0);
        queue_cmd(ukvt_pkg::CMD_UPDATE, '1, '1, '0);
        queue_cmd(ukvt_pkg::CMD_READ, '1, '1, POS_W'(0));
        queue_cmd(ukvt_pkg::CMD_READ, '0, '0, POS_W'(2));
        queue_cmd(ukvt_pkg::CMD_READ, '0, '0, POS_W'(3));
        queue_cmd(ukvt_pkg::CMD_READ, '0, '0, '1);
        queue_cmd(CMD_SPARE_LO, '1, '1, '1);
        queue_cmd(CMD_SPARE_HI, '0, '1, '0);
        queue_cmd(ukvt_pkg::CMD_ERASE, '0, '0, '0);
        queue_cmd(ukvt_pkg::CMD_READ, '0, '0, POS_W'(0));
        queue_cmd(ukvt_pkg::CMD_ERASE, KEY_W'(32'h1234_5678), '0, '0);
        queue_cmd(ukvt_pkg::CMD_ERASE, '0, '0, '0);
        queue_cmd(ukvt_pkg::CMD_LOOKUP, '0, '0, '0);
        queue_cmd(ukvt_pkg::CMD_UPDATE, '1, '0, '0);
        wait_drained();

        make_pool(6);
        run_mix(300, 3, 2, 3, 2, 3, 3, 1);
        make_pool(20);
        run_mix(400, 4, 2, 2, 2, 3, 3, 1);
        make_pool(48);
        run_mix(400, 6, 2, 3, 2, 3, 2, 1);

        // Fill the table past capacity, work on it while full, then empty it again.
        // The low bits of each key hold its pool index, so every key is distinct.
        make_pool(300);
        for (int i = 0; i < 300; i++)
            key_pool[i] = KEY_W'(i) ^ (KEY_W'($urandom) << 9);
        for (int i = 0; i < 270; i++)
            queue_cmd(ukvt_pkg::CMD_INSERT, key_pool[i], VAL_W'($urandom),
                      POS_W'($urandom_range(0, 255)));
        run_mix(80, 3, 2, 3, 2, 2, 2, 1);
        wait_drained();
        for (int i = 0; i < 300; i++)
        begin
            queue_cmd(ukvt_pkg::CMD_ERASE, key_pool[i], VAL_W'($urandom),
                      POS_W'($urandom_range(0, 255)));
            if (i % 10 == 0)
                queue_cmd(ukvt_pkg::CMD_READ, '0, '0, POS_W'($urandom_range(0, 255)));
        end

        make_pool(12);
        run_mix(150, 3, 2, 3, 3, 3, 3, 1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
